// File: design/waveform_window_features_macros.svh
`ifndef WAVEFORM_WINDOW_FEATURES_MACROS_SVH
`define WAVEFORM_WINDOW_FEATURES_MACROS_SVH

// same-cycle implication
`define WWF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wwf_pkg.sv
package wwf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int CNT_W       = 13;
    localparam int ADDR_W      = 12;
    localparam int EN_W        = 59;
    localparam int SUM_W       = 36;
    localparam int CROSS_W     = 12;
    localparam int FS_W        = 16;
    localparam int UNUM_W      = 96;
    localparam int UDEN_W      = 64;
    localparam int PADDR_W     = 3;

    localparam logic [PADDR_W-1:0] REG_SAMPLE_RATE = PADDR_W'(0);
    localparam logic [FS_W-1:0]    FS_RESET        = FS_W'(100);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        rms_level;
        logic [23:0]        peak_magnitude;
        logic signed [31:0] mean_level;
        logic [31:0]        std_dev;
        logic [29:0]        period_seconds;
        logic               period_valid;
        logic [31:0]        snr_ratio;
        logic [CNT_W-1:0]   sample_count;
        logic               window_truncated;
    } t_out_word;

    typedef struct packed {
        logic go;
        logic sqrt;
    } t_unit_cmd;

endpackage

// File: design/wwf_ram.sv
module wwf_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/wwf_divsqrt.sv
module wwf_divsqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wwf_pkg::t_unit_cmd        i_cmd,
    input  logic [wwf_pkg::UNUM_W-1:0] i_num,
    input  logic [wwf_pkg::UDEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [wwf_pkg::UNUM_W-1:0] o_res
);
    import wwf_pkg::*;

    logic [UNUM_W-1:0] r_num;
    logic [UNUM_W-1:0] r_quo;
    logic [UDEN_W-1:0] r_den;
    logic [UDEN_W-1:0] r_rem;
    logic [6:0]        r_cnt;
    logic              r_sqrt;
    logic              r_run;
    logic              r_done;

    logic [UDEN_W:0]   w_a;
    logic [UDEN_W:0]   w_b;
    logic [UDEN_W+1:0] w_diff;
    logic              w_ok;

    always_comb begin
        if (r_sqrt) begin
            w_a = {r_rem[UDEN_W-2:0], r_num[UNUM_W-1 -: 2]};
            w_b = (UDEN_W+1)'({r_quo[47:0], 2'b01});
        end else begin
            w_a = {r_rem, r_num[UNUM_W-1]};
            w_b = {1'b0, r_den};
        end
        w_diff = {1'b0, w_a} - {1'b0, w_b};
        w_ok   = !w_diff[UDEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_run  <= 1'b1;
                r_sqrt <= i_cmd.sqrt;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= i_cmd.sqrt ? 7'd48 : 7'd96;
            end else if (r_run) begin
                r_rem <= w_ok ? w_diff[UDEN_W-1:0] : w_a[UDEN_W-1:0];
                r_quo <= {r_quo[UNUM_W-2:0], w_ok};
                r_num <= r_sqrt ? {r_num[UNUM_W-3:0], 2'b00} : {r_num[UNUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_quo;
endmodule

// File: design/waveform_window_features.sv
// window statistics over a stream of signed 24-bit samples
// input: a word (sample, last) is taken at a clock edge with start high and
// busy low; while a window is filling, a sample can be taken every cycle.
// the word with last set ends the window; samples past 4096 are dropped and
// flagged, and a dropped word with last set still ends the window.
// after the last word busy stays high through the setup states prep0 and
// prep1, twelve passes through one shared bit-serial divide/square-root
// unit (a load and a wait state each) and the output state.
// the result word appears on o_result for one cycle with o_done high, and
// busy drops in that same cycle; the receiver cannot stall, so it must take
// the word then. the prefix energy store is a 4096-entry ram, one write per
// kept sample and one read per window.
// sample_rate_hz sits at apb byte address 0; write it only while idle.
// reset (synchronous, active low) clears the window and sets the rate to 100.
module waveform_window_features (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  wwf_pkg::t_in_word         i_word,
    output logic                      o_done,
    output wwf_pkg::t_out_word        o_result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [wwf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import wwf_pkg::*;
    `include "waveform_window_features_macros.svh"

    typedef enum logic [2:0] {ST_IDLE, ST_PREP0, ST_PREP1, ST_LOAD, ST_WAIT, ST_OUT} t_state;
    typedef enum logic [3:0] {
        SP_RMS_DIV, SP_RMS_SQRT, SP_MEAN_DIV, SP_VAR_DIV1, SP_VAR_DIV2, SP_STD_SQRT,
        SP_PER_DIV, SP_FIRST_DIV, SP_FIRST_SQRT, SP_SECOND_DIV, SP_SECOND_SQRT, SP_SNR_DIV
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic [FS_W-1:0]        r_fs;
    logic [CNT_W-1:0]       r_cnt;
    logic [EN_W-1:0]        r_energy;
    logic signed [SUM_W-1:0] r_sum;
    logic [23:0]            r_peak;
    logic [CROSS_W-1:0]     r_cross;
    logic                   r_prneg;
    logic                   r_ovf;

    logic [EN_W+CNT_W-1:0]  r_en;
    logic [63:0]            r_s2lo;
    logic [71:0]            r_var;
    logic [27:0]            r_fsx;
    logic [EN_W-1:0]        r_efirst;
    logic [UNUM_W-1:0]      r_tmp;
    logic [31:0]            r_rms;
    logic [31:0]            r_mean;
    logic [31:0]            r_std;
    logic [29:0]            r_period;
    logic [47:0]            r_rn;
    logic [47:0]            r_rs;
    logic [31:0]            r_snr;
    logic                   r_done;
    t_out_word              r_out;

    logic                   w_acc;
    logic                   w_neg;
    logic [23:0]            w_mag;
    logic [47:0]            w_sq;
    logic                   w_room;
    logic [EN_W-1:0]        w_energy_nx;
    logic [SUM_W-1:0]       w_abs_sum;
    logic [CNT_W-1:0]       w_half;
    logic [35:0]            w_hl;
    logic [7:0]             w_hh;
    logic [71:0]            w_s2;
    logic [EN_W-1:0]        w_rdata;
    logic                   w_valid;
    t_unit_cmd              w_cmd;
    logic [UNUM_W-1:0]      w_num;
    logic [UDEN_W-1:0]      w_den;
    logic                   w_udone;
    logic [UNUM_W-1:0]      w_res;
    logic [31:0]            w_mean_q;

    assign w_acc       = start && !busy;
    assign w_neg       = i_word.sample[SAMPLE_BITS-1];
    assign w_mag       = w_neg ? 24'(-i_word.sample) : 24'(i_word.sample);
    assign w_sq        = w_mag * w_mag;
    assign w_room      = r_cnt < CNT_W'(MAX_SAMPLES);
    assign w_energy_nx = r_energy + EN_W'(w_sq);
    assign w_abs_sum   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_half      = r_cnt >> 1;
    assign w_valid     = (r_cross != '0) && (r_fs != '0);
    assign w_hl        = w_abs_sum[35:32] * w_abs_sum[31:0];
    assign w_hh        = w_abs_sum[35:32] * w_abs_sum[35:32];
    assign w_s2 = 72'(r_s2lo) + (72'(w_hl) << 33) + (72'(w_hh) << 64);
    assign w_mean_q    = w_res[31:0];

    wwf_ram #(.WIDTH(EN_W), .DEPTH(MAX_SAMPLES)) u_prefix (
        .i_clk  (i_clk),
        .i_we   (w_acc && w_room),
        .i_waddr(r_cnt[ADDR_W-1:0]),
        .i_wdata(w_energy_nx),
        .i_raddr(ADDR_W'(w_half - CNT_W'(1))),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_num = '0;
        w_den = UDEN_W'(r_cnt);
        w_cmd.go   = (r_state == ST_LOAD);
        w_cmd.sqrt = 1'b0;
        unique case (r_step)
            SP_RMS_DIV:     w_num = UNUM_W'({r_energy, 16'b0});
            SP_RMS_SQRT:    begin w_num = r_tmp; w_cmd.sqrt = 1'b1; end
            SP_MEAN_DIV:    w_num = UNUM_W'({w_abs_sum, 8'b0});
            SP_VAR_DIV1:    w_num = UNUM_W'({r_var, 16'b0});
            SP_VAR_DIV2:    w_num = r_tmp;
            SP_STD_SQRT:    begin w_num = r_tmp; w_cmd.sqrt = 1'b1; end
            SP_PER_DIV:     begin w_num = UNUM_W'({r_cnt, 17'b0}); w_den = UDEN_W'(r_fsx); end
            SP_FIRST_DIV:   begin w_num = UNUM_W'({r_efirst, 32'b0}); w_den = UDEN_W'(w_half); end
            SP_FIRST_SQRT:  begin w_num = r_tmp; w_cmd.sqrt = 1'b1; end
            SP_SECOND_DIV:  begin
                w_num = UNUM_W'({r_energy - r_efirst, 32'b0});
                w_den = UDEN_W'(r_cnt - w_half);
            end
            SP_SECOND_SQRT: begin w_num = r_tmp; w_cmd.sqrt = 1'b1; end
            SP_SNR_DIV:     begin w_num = UNUM_W'({r_rs, 16'b0}); w_den = UDEN_W'(r_rn); end
            default:        w_num = '0;
        endcase
    end

    wwf_divsqrt u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_udone),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SP_RMS_DIV;
            r_fs     <= FS_RESET;
            r_cnt    <= '0;
            r_energy <= '0;
            r_sum    <= '0;
            r_peak   <= '0;
            r_cross  <= '0;
            r_prneg  <= 1'b0;
            r_ovf    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (psel && penable && pwrite && paddr == REG_SAMPLE_RATE) begin
                r_fs <= pwdata[FS_W-1:0];
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (w_room) begin
                            r_energy <= w_energy_nx;
                            r_sum    <= r_sum + SUM_W'(i_word.sample);
                            if (w_mag > r_peak) begin
                                r_peak <= w_mag;
                            end
                            if (r_cnt != '0 && w_neg != r_prneg) begin
                                r_cross <= r_cross + CROSS_W'(1);
                            end
                            r_prneg <= w_neg;
                            r_cnt   <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_word.last) begin
                            r_state <= ST_PREP0;
                        end
                    end
                end
                ST_PREP0: begin
                    r_en    <= r_energy * r_cnt;
                    r_s2lo  <= w_abs_sum[31:0] * w_abs_sum[31:0];
                    r_fsx   <= r_fs * r_cross;
                    r_state <= ST_PREP1;
                end
                ST_PREP1: begin
                    r_efirst <= w_rdata;
                    r_var    <= (w_s2 <= 72'(r_en)) ? 72'(r_en) - w_s2 : '0;
                    r_step   <= SP_RMS_DIV;
                    r_state  <= ST_LOAD;
                end
                ST_LOAD: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (w_udone) begin
                        r_tmp   <= w_res;
                        r_state <= ST_LOAD;
                        r_step  <= t_step'(r_step + 4'd1);
                        unique case (r_step)
                            SP_RMS_SQRT:    r_rms <= w_res[31:0];
                            SP_MEAN_DIV:    r_mean <= r_sum[SUM_W-1] ? -w_mean_q : w_mean_q;
                            SP_STD_SQRT:    r_std <= w_res[31:0];
                            SP_PER_DIV:     r_period <= w_valid ? w_res[29:0] : '0;
                            SP_FIRST_SQRT:  r_rn <= w_res[47:0];
                            SP_SECOND_SQRT: r_rs <= w_res[47:0];
                            SP_SNR_DIV: begin
                                r_state <= ST_OUT;
                                if (w_half == '0 || r_efirst == '0 || r_rn == '0) begin
                                    r_snr <= '0;
                                end else if (w_res[UNUM_W-1:32] != '0) begin
                                    r_snr <= '1;
                                end else begin
                                    r_snr <= w_res[31:0];
                                end
                            end
                            default: r_snr <= r_snr;
                        endcase
                    end
                end
                ST_OUT: begin
                    r_out.rms_level        <= r_rms;
                    r_out.peak_magnitude   <= r_peak;
                    r_out.mean_level       <= r_mean;
                    r_out.std_dev          <= r_std;
                    r_out.period_seconds   <= r_period;
                    r_out.period_valid     <= w_valid;
                    r_out.snr_ratio        <= r_snr;
                    r_out.sample_count     <= r_cnt;
                    r_out.window_truncated <= r_ovf;
                    r_done   <= 1'b1;
                    r_cnt    <= '0;
                    r_energy <= '0;
                    r_sum    <= '0;
                    r_peak   <= '0;
                    r_cross  <= '0;
                    r_prneg  <= 1'b0;
                    r_ovf    <= 1'b0;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;
    assign prdata   = (paddr == REG_SAMPLE_RATE) ? 32'(r_fs) : '0;
    assign pready   = 1'b1;

    `WWF_ASSERT_NEXT(a_done_single, o_done, !o_done, "result word repeated")
    `WWF_ASSERT_NEXT(a_last_busy, start && !busy && i_word.last, busy, "no busy after last")
    `WWF_ASSERT_NOW(a_done_idle, o_done, !busy, "result while busy")
endmodule

// File: tb/sv/waveform_window_features_tb.sv
module waveform_window_features_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wwf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_in_word            i_word = '0;
    logic                o_done;
    t_out_word           o_result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    waveform_window_features u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_word(i_word), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // window statistics state
    logic [FS_W-1:0]  rate_hz = FS_RESET;
    int               win_count = 0;
    logic [EN_W-1:0]  win_energy = '0;
    longint           win_sum = 0;
    logic [23:0]      win_peak = '0;
    int               win_cross = 0;
    bit               win_prev_neg = 1'b0;
    bit               win_dropped = 1'b0;
    logic [EN_W-1:0]  energy_prefix [MAX_SAMPLES];

    t_out_word        pending_stats [$];
    int               mismatches = 0;
    int               idle_cycles = 0;

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= x) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] root_level(input logic [63:0] e, input longint n,
                                               input int frac);
        logic [127:0] x;
        if (n == 0) return '0;
        x = (128'(e) * 128'(n)) << (2 * frac);
        return 64'(128'(isqrt(x)) / 128'(n));
    endfunction

    function automatic bit window_step(input t_in_word w, output t_out_word r);
        longint      v;
        longint      mag;
        bit          neg;
        longint      n;
        longint      h;
        longint      mean;
        logic [63:0] e_first;
        logic [63:0] rn;
        logic [63:0] rs;
        logic [127:0] en;
        logic [127:0] s2;
        logic [127:0] var_w;
        logic [127:0] snr;
        longint      abs_sum;
        r = '0;
        v = longint'(w.sample);
        neg = w.sample[SAMPLE_BITS-1];
        if (win_count < MAX_SAMPLES) begin
            mag = neg ? -v : v;
            win_energy = win_energy + EN_W'(mag * mag);
            win_sum += v;
            if (mag > longint'(win_peak)) win_peak = 24'(mag);
            if (win_count > 0 && neg != win_prev_neg) win_cross++;
            win_prev_neg = neg;
            energy_prefix[win_count] = win_energy;
            win_count++;
        end else begin
            win_dropped = 1'b1;
        end
        if (!w.last) return 1'b0;

        n = win_count;
        r.rms_level = 32'(root_level(64'(win_energy), n, 8));
        r.peak_magnitude = win_peak;
        mean = (win_sum * 256) / n;
        r.mean_level = 32'(mean);
        abs_sum = win_sum < 0 ? -win_sum : win_sum;
        en = 128'(win_energy) * 128'(n);
        s2 = 128'(abs_sum) * 128'(abs_sum);
        var_w = (s2 <= en) ? en - s2 : '0;
        r.std_dev = 32'(128'(isqrt(var_w << 16)) / 128'(n));
        if (win_cross > 0 && rate_hz > 0) begin
            r.period_seconds = 30'((2 * n * 65536) / (longint'(rate_hz) * win_cross));
            r.period_valid = 1'b1;
        end
        h = n / 2;
        e_first = h > 0 ? 64'(energy_prefix[h - 1]) : '0;
        if (h > 0 && e_first > 0) begin
            rn = root_level(e_first, h, 16);
            rs = root_level(64'(win_energy) - e_first, n - h, 16);
            if (rn > 0) begin
                snr = (128'(rs) << 16) / 128'(rn);
                r.snr_ratio = (snr > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(snr);
            end
        end
        r.sample_count = CNT_W'(n);
        r.window_truncated = win_dropped;
        win_count = 0;
        win_energy = '0;
        win_sum = 0;
        win_peak = '0;
        win_cross = 0;
        win_prev_neg = 1'b0;
        win_dropped = 1'b0;
        return 1'b1;
    endfunction

    task automatic report(input string fname, input logic [31:0] exp_v,
                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h", fname, exp_v, act_v);
        end
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && ((start && !busy) || o_done || (psel && penable)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (pending_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                e = pending_stats.pop_front();
                report("rms_level", e.rms_level, o_result.rms_level);
                report("peak_magnitude", 32'(e.peak_magnitude), 32'(o_result.peak_magnitude));
                report("mean_level", e.mean_level, o_result.mean_level);
                report("std_dev", e.std_dev, o_result.std_dev);
                report("period_seconds", 32'(e.period_seconds), 32'(o_result.period_seconds));
                report("period_valid", 32'(e.period_valid), 32'(o_result.period_valid));
                report("snr_ratio", e.snr_ratio, o_result.snr_ratio);
                report("sample_count", 32'(e.sample_count), 32'(o_result.sample_count));
                report("window_truncated", 32'(e.window_truncated),
                       32'(o_result.window_truncated));
            end
        end
    end

    int burst_left = 0;

    task automatic send_word(input t_in_word w, input bit use_fixed,
                             input t_out_word fixed);
        t_out_word r;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (window_step(w, r)) pending_stats.push_back(use_fixed ? fixed : r);
    endtask

    task automatic send(input logic signed [23:0] s, input bit lst);
        t_in_word w;
        w.sample = s;
        w.last = lst;
        send_word(w, 1'b0, '0);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [FS_W-1:0] fs);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_SAMPLE_RATE;
        pwdata <= 32'(fs);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rate_hz = fs;
    endtask

    typedef struct {
        logic signed [23:0] s;
        bit                 lst;
        bit                 fixed;
    } t_row;

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'($urandom_range(0, 15)) - 24'sd8;
            3: return 24'($urandom_range(0, 4095)) - 24'sd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        t_row      rows [$];
        t_out_word fx;
        t_in_word  w;
        int        items;
        int        len;
        logic [FS_W-1:0] fs;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{24'sd0, 1'b1, 1'b1},
            '{24'sh800000, 1'b1, 1'b1},
            '{24'sh7FFFFF, 1'b1, 1'b0},
            '{24'sd0, 1'b0, 1'b0}, '{-24'sd1, 1'b0, 1'b0}, '{24'sd0, 1'b0, 1'b0},
            '{24'sh800000, 1'b0, 1'b0}, '{24'sh7FFFFF, 1'b1, 1'b0},
            '{24'sd0, 1'b0, 1'b0}, '{24'sd0, 1'b0, 1'b0}, '{24'sd5, 1'b0, 1'b0},
            '{24'sd7, 1'b1, 1'b0},
            '{24'sd100, 1'b0, 1'b0}, '{24'sd100, 1'b0, 1'b0}, '{-24'sd300, 1'b1, 1'b0},
            '{-24'sd3, 1'b0, 1'b0}, '{-24'sd3, 1'b0, 1'b0}, '{-24'sd4, 1'b1, 1'b0}
        };
        foreach (rows[i]) begin
            w.sample = rows[i].s;
            w.last = rows[i].lst;
            fx = '0;
            fx.sample_count = CNT_W'(1);
            if (rows[i].s == 24'sh800000) begin
                fx.peak_magnitude = 24'h800000;
                fx.rms_level = 32'h8000_0000;
                fx.mean_level = 32'sh8000_0000;
            end
            send_word(w, rows[i].fixed, fx);
        end

        items = rows.size();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: fs = 16'd1;
                1: fs = 16'hFFFF;
                2: fs = 16'd0;
                3: fs = FS_RESET;
                default: fs = 16'($urandom_range(1, 65535));
            endcase
            write_rate(fs);
            for (int wn = 0; wn < 8; wn++) begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(40, 80);
                    1: len = 1;
                    default: len = $urandom_range(2, 12);
                endcase
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        send((k % 2) ? rand_sample() : -rand_sample(), k == len - 1);
                    else
                        send(rand_sample(), k == len - 1);
                end
                items += len;
            end
        end
        while (items < 600) begin
            len = $urandom_range(1, 16);
            for (int k = 0; k < len; k++) send(rand_sample(), k == len - 1);
            items += len;
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/wwf_pkg.sv
design/wwf_ram.sv
design/wwf_divsqrt.sv
design/waveform_window_features.sv
tb/sv/waveform_window_features_tb.sv
